### sv/meter_frame_builder_crc16_macros.svh
// Assertion macros used by the meter frame builder top level.
`ifndef METER_FRAME_BUILDER_CRC16_MACROS_SVH
`define METER_FRAME_BUILDER_CRC16_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mfb_pkg.sv
// Types, constants and CRC function of the meter frame builder.
`default_nettype none
package mfb_pkg;

	localparam logic [7:0]  START_BYTE      = 8'h68;
	localparam logic [7:0]  END_BYTE        = 8'h16;
	localparam logic [7:0]  TYPE_BYTE       = 8'h00;
	localparam logic [7:0]  SEQ_BYTE        = 8'h00;
	localparam logic [15:0] LEN_FIELD_BIAS  = 16'd18;
	localparam logic [7:0]  VERSION_RESET   = 8'h0A;
	localparam logic [15:0] CRC_INIT_RESET  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'h1021;
	localparam logic [15:0] CRC_POLY_REFL   = 16'h8408;
	localparam int          HDR_BYTES       = 15;
	localparam int          MAX_PAYLOAD_DEF = 182;
	localparam int          QUEUE_DEPTH_DEF = 4;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		CFG_VERSION     = 2'd0,
		CFG_CRC_INIT    = 2'd1,
		CFG_CRC_REFLECT = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		CMD_HEADER  = 1'b0,
		CMD_PAYLOAD = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		OP_HDR = 2'd0,
		OP_PAY = 2'd1,
		OP_REJ = 2'd2
	} op_kind_t;

	// One queued operation for the back end.
	typedef struct packed {
		op_kind_t    kind;
		logic        tail;      // close the frame after this op
		logic [47:0] meter_id;
		logic [15:0] data_id;
		logic [7:0]  control_code;
		logic [15:0] frame_len; // payload length plus overhead
		logic [7:0]  data;      // payload byte
	} mfb_op_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_HDR    = 3'd1,
		ST_CRC_LO = 3'd2,
		ST_CRC_HI = 3'd3,
		ST_END    = 3'd4
	} back_state_t;

	// One byte through the CRC-16 register, MSB first or reflected.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
		input logic reflect);
		logic [15:0] c;
		int i;
		c = crc;
		if (reflect) begin
			c = c ^ {8'h00, b};
			for (i = 0; i < 8; i++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
			end
		end else begin
			c = c ^ {b, 8'h00};
			for (i = 0; i < 8; i++) begin
				c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### sv/meter_frame_builder_crc16.sv
// Top level of the meter frame builder: config registers, front, queue, back.
// Usage:
//   s_* channel takes one command per transaction. s_tuser = 0 is a header
//   (meter id, data id, control code, payload length), s_tuser = 1 carries
//   one payload byte. Payload bytes with no open frame are taken and dropped.
//   m_* channel delivers one frame byte per transaction; m_tlast marks the
//   closing 0x16 byte, and a rejected header (length above MAX_PAYLOAD) gives
//   one transaction with m_tuser = 1, m_tlast = 1 and data 0.
// Timing:
//   A command reaches m_* through the queue and the output register. Payload
//   bytes stream at 1 per cycle while m_tready is high. A header gives 15
//   output bytes, the CRC and end byte 3 more; the back end serializer sets
//   these figures. The input side runs ahead through a QUEUE_DEPTH-entry
//   command queue and stalls (s_tready low) only when that queue is full.
// Reset (arst_n low): no frame open, queue empty, m_tvalid low, registers
// back to version 0x0A, CRC init 0xFFFF, MSB-first CRC. No clearing pass.
// Receiver stall: the output register holds its byte while m_tready is low;
// the back end waits and the queue fills before input is held off.
`default_nettype none
`include "meter_frame_builder_crc16_macros.svh"
module meter_frame_builder_crc16 #(
	parameter int MAX_PAYLOAD = mfb_pkg::MAX_PAYLOAD_DEF,
	parameter int QUEUE_DEPTH = mfb_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// meter_id[47:0], data_id[63:48], control_code[71:64],
	// payload_length[87:72], payload_byte[95:88]
	input  wire [mfb_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire                              s_tuser,   // cmd
	input  wire                              s_tvalid,
	output logic                             s_tready,
	output logic [mfb_pkg::OUT_DATA_W-1:0]   m_tdata,   // tx_byte[7:0]
	output logic                             m_tlast,   // last
	output logic                             m_tuser,   // rejected
	output logic                             m_tvalid,
	input  wire                              m_tready,
	input  wire                              cfg_we,
	input  wire [1:0]                        cfg_index,
	input  wire [mfb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import mfb_pkg::*;

	logic [7:0]  version_q;
	logic [15:0] crc_init_q;
	logic        crc_reflect_q;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_valid;
	mfb_op_t     q_in;
	mfb_op_t     q_head;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q     <= VERSION_RESET;
			crc_init_q    <= CRC_INIT_RESET;
			crc_reflect_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VERSION:     version_q     <= cfg_wdata[7:0];
				CFG_CRC_INIT:    crc_init_q    <= cfg_wdata;
				CFG_CRC_REFLECT: crc_reflect_q <= cfg_wdata[0];
				default:         ;
			endcase
		end
	end

	// front: classify commands and track frame state
	mfb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (q_in)
	);

	mfb_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_in),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_op    (q_head)
	);

	// back: byte serializer, CRC and output register
	mfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_valid),
		.head_op      (q_head),
		.q_pop        (q_pop),
		.version_byte (version_q),
		.crc_init     (crc_init_q),
		.crc_reflect  (crc_reflect_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser)
	);

	`MFB_ASSERT_NOW(a_no_push_full, clk, arst_n, q_push && q_full, 1'b0,
		"push into full command queue")
	`MFB_ASSERT_NOW(a_pop_needs_head, clk, arst_n, q_pop, q_valid,
		"pop from empty command queue")
	`MFB_ASSERT_NOW(a_reject_shape, clk, arst_n, m_tvalid && m_tuser,
		m_tlast && (m_tdata == 8'h00), "rejection must be a single zero last byte")
	`MFB_ASSERT_NOW(a_end_byte, clk, arst_n, m_tvalid && m_tlast && !m_tuser,
		m_tdata == END_BYTE, "frame must close with end byte")

endmodule
`default_nettype wire

### sv/mfb_fifo.sv
// Small operation queue between the front and back ends.
`default_nettype none
module mfb_fifo #(
	parameter int DEPTH = mfb_pkg::QUEUE_DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  mfb_pkg::mfb_op_t push_op,
	input  wire             pop,
	output logic            full,
	output logic            head_valid,
	output mfb_pkg::mfb_op_t head_op
);
	import mfb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mfb_op_t        mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/mfb_front.sv
// Front end: accepts input items, tracks the open frame, queues operations.
`default_nettype none
module mfb_front #(
	parameter int MAX_PAYLOAD = mfb_pkg::MAX_PAYLOAD_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [mfb_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire                              s_tuser,
	input  wire                              q_full,
	output logic                             q_push,
	output mfb_pkg::mfb_op_t                 q_op
);
	import mfb_pkg::*;

	logic        frame_open_q;
	logic [7:0]  bytes_left_q;
	logic        accept;
	logic [15:0] len;
	logic        too_long;
	logic        pay_tail;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign len      = s_tdata[87:72];
	assign too_long = (len > 16'(MAX_PAYLOAD));
	assign pay_tail = (bytes_left_q <= 8'd1);

	always_comb begin
		q_op.meter_id     = s_tdata[47:0];
		q_op.data_id      = s_tdata[63:48];
		q_op.control_code = s_tdata[71:64];
		q_op.frame_len    = len + LEN_FIELD_BIAS;
		q_op.data         = s_tdata[95:88];
		q_op.kind         = OP_PAY;
		q_op.tail         = pay_tail;
		q_push            = 1'b0;
		if (s_tuser == CMD_HEADER) begin
			q_op.kind = too_long ? OP_REJ : OP_HDR;
			q_op.tail = (len == 16'd0);
			q_push    = accept;
		end else begin
			// payload with no open frame is dropped
			q_push = accept && frame_open_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			if (s_tuser == CMD_HEADER) begin
				frame_open_q <= !too_long && (len != 16'd0);
				bytes_left_q <= too_long ? 8'd0 : len[7:0];
			end else if (frame_open_q) begin
				frame_open_q <= !pay_tail;
				bytes_left_q <= pay_tail ? 8'd0 : bytes_left_q - 8'd1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/mfb_back.sv
// Back end: serializes queued operations into frame bytes with CRC-16.
`default_nettype none
module mfb_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              head_valid,
	input  mfb_pkg::mfb_op_t                 head_op,
	output logic                             q_pop,
	input  wire [7:0]                        version_byte,
	input  wire [15:0]                       crc_init,
	input  wire                              crc_reflect,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [mfb_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast,
	output logic                             m_tuser
);
	import mfb_pkg::*;

	localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

	back_state_t state_q, state_nx;
	logic [3:0]  idx_q, idx_nx;
	logic [15:0] crc_q, crc_nx;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic        m_tlast_q;
	logic        m_tuser_q;
	logic        advance;
	logic        emit;
	logic [7:0]  byte_nx;
	logic        last_nx;
	logic        rej_nx;
	logic [7:0]  hdr_byte;

	assign advance  = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		case (idx_q)
			4'd1:    hdr_byte = head_op.meter_id[7:0];
			4'd2:    hdr_byte = head_op.meter_id[15:8];
			4'd3:    hdr_byte = head_op.meter_id[23:16];
			4'd4:    hdr_byte = head_op.meter_id[31:24];
			4'd5:    hdr_byte = head_op.meter_id[39:32];
			4'd6:    hdr_byte = head_op.meter_id[47:40];
			4'd7:    hdr_byte = TYPE_BYTE;
			4'd8:    hdr_byte = version_byte;
			4'd9:    hdr_byte = head_op.control_code;
			4'd10:   hdr_byte = head_op.frame_len[7:0];
			4'd11:   hdr_byte = head_op.frame_len[15:8];
			4'd12:   hdr_byte = head_op.data_id[7:0];
			4'd13:   hdr_byte = head_op.data_id[15:8];
			4'd14:   hdr_byte = SEQ_BYTE;
			default: hdr_byte = START_BYTE;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && advance) begin
					case (head_op.kind)
						OP_HDR:  state_nx = ST_HDR;
						OP_PAY:  state_nx = head_op.tail ? ST_CRC_LO : ST_IDLE;
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_HDR: begin
				if (advance && idx_q == HDR_LAST) begin
					state_nx = head_op.tail ? ST_CRC_LO : ST_IDLE;
				end
			end
			ST_CRC_LO: if (advance) state_nx = ST_CRC_HI;
			ST_CRC_HI: if (advance) state_nx = ST_END;
			ST_END:    if (advance) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		emit    = 1'b0;
		byte_nx = 8'h00;
		last_nx = 1'b0;
		rej_nx  = 1'b0;
		q_pop   = 1'b0;
		crc_nx  = crc_q;
		idx_nx  = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && advance) begin
					emit = 1'b1;
					case (head_op.kind)
						OP_HDR: begin
							byte_nx = START_BYTE;
							crc_nx  = crc16_byte(crc_init, START_BYTE, crc_reflect);
							idx_nx  = 4'd1;
						end
						OP_PAY: begin
							byte_nx = head_op.data;
							crc_nx  = crc16_byte(crc_q, head_op.data, crc_reflect);
							q_pop   = 1'b1;
						end
						default: begin
							last_nx = 1'b1;
							rej_nx  = 1'b1;
							q_pop   = 1'b1;
						end
					endcase
				end
			end
			ST_HDR: begin
				if (advance) begin
					emit    = 1'b1;
					byte_nx = hdr_byte;
					crc_nx  = crc16_byte(crc_q, hdr_byte, crc_reflect);
					idx_nx  = idx_q + 4'd1;
					q_pop   = (idx_q == HDR_LAST);
				end
			end
			ST_CRC_LO: begin
				emit    = advance;
				byte_nx = crc_q[7:0];
			end
			ST_CRC_HI: begin
				emit    = advance;
				byte_nx = crc_q[15:8];
			end
			ST_END: begin
				emit    = advance;
				byte_nx = END_BYTE;
				last_nx = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			crc_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			idx_q   <= idx_nx;
			crc_q   <= crc_nx;
			if (advance) begin
				m_tvalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			m_tdata_q <= byte_nx;
			m_tlast_q <= last_nx;
			m_tuser_q <= rej_nx;
		end
	end

endmodule
`default_nettype wire

### tb/sv/tb_meter_frame_builder_crc16.sv
// Self-checking testbench of the meter frame builder with CRC-16 framing.
`default_nettype none
module tb_meter_frame_builder_crc16;
	timeunit 1ns;
	timeprecision 1ps;

	import mfb_pkg::*;

	// Payload limit handed to the block; headers above it are rejected.
	localparam int PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
	// Cycles allowed after the last expected byte before a register write or the end.
	// Only dropped payload commands can still be in flight then.
	localparam int SETTLE_CYCLES = 40;
	// Receiver hold-off long enough to fill the command queue and stall s_tready.
	localparam int HOLD_CYCLES = 300;
	// Watchdog: far above the slowest legal run (every byte behind a long stall).
	localparam int CYCLE_LIMIT = 5_000_000;

	// One frame byte as it leaves on the m_* channel.
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic       rejected;
	} frame_byte_t;

	// Frame predictor and store of bytes still due on the output.
	class frame_scoreboard;
		frame_byte_t expected_bytes[$];
		// Register copies
		logic [7:0]  version;
		logic [15:0] crc_seed;
		logic        reflect;
		// Frame state
		bit          frame_open;
		logic [7:0]  bytes_left;
		logic [15:0] crc_acc;
		// Statistics
		int          mismatches;
		int          checked;
		int          frames_closed;
		int          rejects;

		function new();
			version       = VERSION_RESET;
			crc_seed      = CRC_INIT_RESET;
			reflect       = 1'b0;
			frame_open    = 0;
			bytes_left    = '0;
			crc_acc       = '0;
			mismatches    = 0;
			checked       = 0;
			frames_closed = 0;
			rejects       = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] value);
			case (idx)
				CFG_VERSION: begin
					version = value[7:0];
				end
				CFG_CRC_INIT: begin
					crc_seed = value;
				end
				CFG_CRC_REFLECT: begin
					reflect = value[0];
				end
				default: begin
				end
			endcase
		endfunction

		// Bit-serial CRC update, feedback computed per data bit.
		function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
			logic [15:0] c;
			logic        fb;
			int          i;
			c = crc;
			for (i = 0; i < 8; i++) begin
				if (reflect) begin
					fb = c[0] ^ b[i];
					c = (c >> 1) ^ (fb ? CRC_POLY_REFL : 16'h0000);
				end else begin
					fb = c[15] ^ b[7 - i];
					c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
				end
			end
			return c;
		endfunction

		function void put(logic [7:0] b, logic l, logic r);
			frame_byte_t e;
			e.tx_byte  = b;
			e.last     = l;
			e.rejected = r;
			expected_bytes.push_back(e);
		endfunction

		function void put_data(logic [7:0] b);
			crc_acc = crc_update(crc_acc, b);
			put(b, 1'b0, 1'b0);
		endfunction

		// CRC low, CRC high, end byte; frame closes.
		function void put_tail();
			put(crc_acc[7:0], 1'b0, 1'b0);
			put(crc_acc[15:8], 1'b0, 1'b0);
			put(END_BYTE, 1'b1, 1'b0);
			frame_open = 0;
			bytes_left = '0;
			frames_closed++;
		endfunction

		// Accepted command: queue the bytes it causes, return how many.
		function int note_command(cmd_t cmd, logic [IN_DATA_W-1:0] d);
			int          n0;
			int          i;
			logic [47:0] mid;
			logic [15:0] did;
			logic [7:0]  ctl;
			logic [15:0] len;
			logic [7:0]  pb;
			logic [15:0] flen;
			n0 = expected_bytes.size();
			{pb, len, ctl, did, mid} = d;
			if (cmd == CMD_HEADER) begin
				// A header always abandons whatever frame was open.
				frame_open = 0;
				bytes_left = '0;
				if (len > PAYLOAD_LIMIT) begin
					put(8'h00, 1'b1, 1'b1);
					rejects++;
				end else begin
					flen = len + LEN_FIELD_BIAS;
					crc_acc = crc_seed;
					put_data(START_BYTE);
					for (i = 0; i < 6; i++) begin
						put_data(mid[8*i +: 8]);
					end
					put_data(TYPE_BYTE);
					put_data(version);
					put_data(ctl);
					put_data(flen[7:0]);
					put_data(flen[15:8]);
					put_data(did[7:0]);
					put_data(did[15:8]);
					put_data(SEQ_BYTE);
					if (len == 0) begin
						put_tail();
					end else begin
						frame_open = 1;
						bytes_left = len[7:0];
					end
				end
			end else if (frame_open) begin
				put_data(pb);
				if (bytes_left != 0) begin
					bytes_left--;
				end
				if (bytes_left == 0) begin
					put_tail();
				end
			end
			return expected_bytes.size() - n0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t ns: %s", $realtime, msg);
			end
		endfunction

		// Accepted output byte against the oldest expectation.
		function void check_byte(logic [7:0] b, logic l, logic r);
			frame_byte_t e;
			checked++;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte: data %h last %b rejected %b", b, l, r));
			end else begin
				e = expected_bytes.pop_front();
				if (b !== e.tx_byte || l !== e.last || r !== e.rejected) begin
					report($sformatf({"byte mismatch: expected data %h last %b rejected %b,",
						" got data %h last %b rejected %b"},
						e.tx_byte, e.last, e.rejected, b, l, r));
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic [IN_DATA_W-1:0]  s_tdata;   // meter_id, data_id, control_code, payload_length, payload_byte
	logic                  s_tuser;   // cmd
	logic                  s_tvalid;
	wire                   s_tready;
	wire  [OUT_DATA_W-1:0] m_tdata;   // tx_byte
	wire                   m_tlast;   // last
	wire                   m_tuser;   // rejected
	wire                   m_tvalid;
	logic                  m_tready;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	frame_scoreboard sb;
	int  cycles;
	int  live_commands;   // accepted commands that caused output
	int  settings_run;
	bit  hold_request;    // asks the receiver for one long hold-off
	bit  steady;          // no idling on either side while set

	meter_frame_builder_crc16 #(
		.MAX_PAYLOAD(PAYLOAD_LIMIT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still due", cycles,
				sb.expected_bytes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Idle length: mostly short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Output monitor: every m_* transaction is checked in order.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_byte(m_tdata, m_tlast, m_tuser);
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (stall_left > 0 && !steady) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = 0;
				if (!steady && $urandom_range(0, 5) == 0) begin
					stall_left = idle_len();
				end
			end
		end
	end

	// One command transaction; the predictor sees it once it is accepted.
	task automatic send_command(input cmd_t cmd, input logic [IN_DATA_W-1:0] d);
		int gap;
		gap = (steady || $urandom_range(0, 3) != 0) ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (sb.note_command(cmd, d) > 0) begin
			live_commands++;
		end
	endtask

	// Header: payload_byte slot is don't-care, filled at random.
	task automatic send_header(input logic [47:0] mid, input logic [15:0] did,
		input logic [7:0] ctl, input logic [15:0] len);
		send_command(CMD_HEADER, {8'($urandom), len, ctl, did, mid});
	endtask

	// Payload byte: header slots are don't-care, filled at random.
	task automatic send_payload(input logic [7:0] pb);
		send_command(CMD_PAYLOAD, {pb, 16'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom), 32'($urandom)});
	endtask

	// Header with random fields, then the first 'sent' of its payload bytes.
	task automatic send_frame(input int len, input int sent);
		int i;
		send_header({16'($urandom), 32'($urandom)}, 16'($urandom), 8'($urandom), 16'(len));
		for (i = 0; i < sent; i++) begin
			send_payload(8'($urandom));
		end
	endtask

	// Let every expected byte out, then let stray commands drain.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// All three registers, back to back; only called while the block is idle.
	task automatic write_settings(input logic [7:0] ver, input logic [15:0] init,
		input logic refl);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_VERSION;
		cfg_wdata <= {8'h00, ver};
		@(posedge clk);
		cfg_index <= CFG_CRC_INIT;
		cfg_wdata <= init;
		@(posedge clk);
		cfg_index <= CFG_CRC_REFLECT;
		cfg_wdata <= {15'h0000, refl};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(CFG_VERSION, {8'h00, ver});
		sb.set_reg(CFG_CRC_INIT, init);
		sb.set_reg(CFG_CRC_REFLECT, {15'h0000, refl});
		settings_run++;
	endtask

	// Mostly complete frames with random content; some cut short, some rejected,
	// some lone payload bytes, dropped when no frame is open.
	task automatic run_random(input int target);
		int goal;
		int k;
		int len;
		int sent;
		goal = live_commands + target;
		while (live_commands < goal) begin
			k = $urandom_range(0, 99);
			if (k < 8) begin
				send_payload(8'($urandom));
			end else if (k < 16) begin
				send_header({16'($urandom), 32'($urandom)}, 16'($urandom), 8'($urandom),
					16'($urandom_range(PAYLOAD_LIMIT + 1, 65535)));
			end else begin
				k = $urandom_range(0, 99);
				if (k < 75) begin
					len = $urandom_range(0, 8);
				end else if (k < 97) begin
					len = $urandom_range(9, 40);
				end else begin
					len = $urandom_range(120, PAYLOAD_LIMIT);
				end
				sent = (len > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
				send_frame(len, sent);
			end
		end
	endtask

	initial begin
		sb = new();
		cycles        = 0;
		live_commands = 0;
		settings_run  = 1;   // reset values count as the first setting
		hold_request  = 0;
		steady        = 0;
		arst_n        = 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= CMD_HEADER;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_VERSION;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset register values.
		send_payload(8'hFF);                                      // nothing open: dropped
		send_header(48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 16'd0);  // empty payload, all ones
		send_header(48'h0, 16'h0000, 8'h00, 16'd0);               // empty payload, all zeros
		send_header(48'h0123_4567_89AB, 16'h1234, 8'h81, 16'hFFFF);        // rejected
		send_header(48'hA5A5_5A5A_F00F, 16'hBEEF, 8'h11, 16'(PAYLOAD_LIMIT + 1)); // just over
		send_header(48'h1122_3344_5566, 16'h7788, 8'h44, 16'(PAYLOAD_LIMIT));     // at limit
		send_payload(8'h00);
		send_payload(8'hFF);
		send_payload(8'h5A);
		send_header(48'h0000_0000_0001, 16'h0002, 8'h03, 16'd2);  // abandons the open frame
		send_payload(8'h00);
		send_payload(8'hFF);
		send_payload(8'h3C);                                      // after close: dropped
		send_header(48'h8000_0000_0000, 16'h8000, 8'h80, 16'd1);
		send_payload(8'hA5);
		wait_idle();

		// Reflected CRC from zero; one full-size frame and a long receiver hold-off.
		write_settings(8'h00, 16'h0000, 1'b1);
		hold_request = 1;
		send_frame(PAYLOAD_LIMIT, PAYLOAD_LIMIT);
		run_random(80);
		wait_idle();

		// Forward CRC, all-ones extremes, no idling on either side.
		write_settings(8'hFF, 16'hFFFF, 1'b0);
		steady = 1;
		run_random(80);
		steady = 0;
		wait_idle();

		// Random settings in both CRC directions.
		write_settings(8'($urandom), 16'($urandom), 1'b1);
		run_random(80);
		wait_idle();
		write_settings(8'($urandom), 16'($urandom), 1'b0);
		run_random(80);
		wait_idle();

		$display("Sent %0d output-producing commands under %0d register settings;",
			live_commands, settings_run);
		$display("checked %0d bytes: %0d frames closed, %0d headers rejected, %0d mismatches.",
			sb.checked, sb.frames_closed, sb.rejects, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
